FILE: design/trmstat_pkg.sv
package trmstat_pkg;

  // Width of the range and mean result fields.
  localparam int DATA_W = 32;
  // Width of the status code.
  localparam int STAT_W = 2;

  // Default sizing of the block.
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  // Entries in the queue between the accumulator and the divider.
  localparam int QUEUE_DEPTH = 2;

  // Fewest valid samples accepted in trim mode; fewer give the too-few status.
  localparam int TRIM_MIN = 4;

  // Status codes carried on the result channel.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_FEW = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_DATA = 2'd2;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_PREP = 5'b00010,
    B_SIGN = 5'b00100,
    B_DIV  = 5'b01000,
    B_DONE = 5'b10000
  } back_state_t;

endpackage

FILE: design/trmstat_front.sv
module trmstat_front #(
  parameter int MAX_SAMPLES = trmstat_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = trmstat_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
  parameter int SUM_W       = SAMPLE_BITS + CNT_W,
  parameter int REC_W       = 1 + CNT_W + SUM_W + 4 * SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   trim_mode,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_missing,
  input  logic                   in_last,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [REC_W-1:0]       q_wdata
);

  logic                          accept;
  logic                          take;
  logic signed [SAMPLE_BITS-1:0] v;
  logic signed [SUM_W-1:0]       v_ext;

  logic [CNT_W-1:0]              count_r, count_nxt, count_upd;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] lo_r, lo_nxt, lo2_r, lo2_nxt;
  logic signed [SAMPLE_BITS-1:0] hi_r, hi_nxt, hi2_r, hi2_nxt;

  assign in_tready = ~q_full;
  assign accept    = in_tvalid & in_tready;
  assign v         = signed'(in_sample);
  assign v_ext     = SUM_W'(v);
  // Samples beyond the capacity of one subsample are dropped.
  assign take      = accept & ~in_missing & (count_r < CNT_W'(MAX_SAMPLES));

  always_comb begin
    count_upd = count_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    lo2_nxt   = lo2_r;
    hi_nxt    = hi_r;
    hi2_nxt   = hi2_r;
    if (take) begin
      count_upd = count_r + CNT_W'(1);
      if (count_r == '0) begin
        sum_nxt = v_ext;
        lo_nxt  = v;
        hi_nxt  = v;
      end else begin
        sum_nxt = sum_r + v_ext;
        if (v < lo_r) begin
          lo2_nxt = lo_r;
          lo_nxt  = v;
        end else if ((count_r == CNT_W'(1)) || (v < lo2_r)) begin
          lo2_nxt = v;
        end
        if (hi_r < v) begin
          hi2_nxt = hi_r;
          hi_nxt  = v;
        end else if ((count_r == CNT_W'(1)) || (hi2_r < v)) begin
          hi2_nxt = v;
        end
      end
    end
    // The last word hands the totals to the back end and starts afresh.
    count_nxt = (accept & in_last) ? '0 : count_upd;
  end

  assign q_push  = accept & in_last;
  assign q_wdata = {trim_mode, count_upd, sum_nxt, lo_nxt, lo2_nxt, hi_nxt, hi2_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    lo_r  <= lo_nxt;
    lo2_r <= lo2_nxt;
    hi_r  <= hi_nxt;
    hi2_r <= hi2_nxt;
  end

endmodule

FILE: design/trmstat_queue.sv
module trmstat_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = trmstat_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: design/trmstat_back.sv
module trmstat_back #(
  parameter int MAX_SAMPLES = trmstat_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = trmstat_pkg::SAMPLE_BITS_DEF,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
  parameter int SUM_W       = SAMPLE_BITS + CNT_W,
  parameter int REC_W       = 1 + CNT_W + SUM_W + 4 * SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  logic [REC_W-1:0]                  q_rdata,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [trmstat_pkg::DATA_W-1:0]    out_range,
  output logic [trmstat_pkg::DATA_W-1:0]    out_mean,
  output logic [trmstat_pkg::STAT_W-1:0]    out_status
);

  import trmstat_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int BCNT_W = $clog2(SUM_W);

  back_state_t state_r, state_nxt;

  logic [REC_W-1:0]       rec_r;
  logic                   rec_trim;
  logic [CNT_W-1:0]       rec_count;
  logic signed [SUM_W-1:0] rec_sum;
  logic signed [SB-1:0]   rec_lo, rec_lo2, rec_hi, rec_hi2;

  logic [STAT_W-1:0]      status_r, status_nxt;
  logic [SB:0]            diff;
  logic [DATA_W-1:0]      range_r;
  logic signed [SUM_W-1:0] num_r, num_nxt;
  logic [CNT_W-1:0]       div_r, div_nxt;
  logic                   neg_r;
  logic [SUM_W-1:0]       quo_r;
  logic [CNT_W-1:0]       rem_r;
  logic [BCNT_W-1:0]      bit_r;
  logic [CNT_W:0]         shifted, trial;
  logic                   fits;
  logic signed [SUM_W-1:0] mean_full;

  logic                   out_valid_r;
  logic [DATA_W-1:0]      out_range_r, out_mean_r;
  logic [STAT_W-1:0]      out_status_r;
  logic                   out_load;

  assign {rec_trim, rec_count, rec_sum, rec_lo, rec_lo2, rec_hi, rec_hi2} = rec_r;

  // Status, numerator and divisor of the mean, and the range difference.
  always_comb begin
    if (rec_trim) begin
      status_nxt = (rec_count < CNT_W'(TRIM_MIN)) ? ST_TOO_FEW : ST_OK;
      num_nxt    = rec_sum - SUM_W'(rec_lo) - SUM_W'(rec_hi);
      div_nxt    = rec_count - CNT_W'(2);
      diff       = (SB + 1)'(rec_hi2) - (SB + 1)'(rec_lo2);
    end else begin
      status_nxt = (rec_count == '0) ? ST_NO_DATA : ST_OK;
      num_nxt    = rec_sum;
      div_nxt    = rec_count;
      diff       = (SB + 1)'(rec_hi) - (SB + 1)'(rec_lo);
    end
  end

  // One restoring step of the unsigned magnitude divide.
  assign shifted   = {rem_r, quo_r[SUM_W-1]};
  assign fits      = (shifted >= {1'b0, div_r});
  assign trial     = shifted - {1'b0, div_r};
  assign mean_full = neg_r ? -signed'(quo_r) : signed'(quo_r);

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign out_load = (state_r == B_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          state_nxt = B_PREP;
        end
      end
      B_PREP: begin
        state_nxt = (status_nxt == ST_OK) ? B_SIGN : B_DONE;
      end
      B_SIGN: begin
        state_nxt = B_DIV;
      end
      B_DIV: begin
        if (bit_r == BCNT_W'(SUM_W - 1)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_rdata;
    end
    if (state_r == B_PREP) begin
      status_r <= status_nxt;
      num_r    <= num_nxt;
      div_r    <= div_nxt;
      range_r  <= DATA_W'(diff);
    end
    if (state_r == B_SIGN) begin
      neg_r <= num_r[SUM_W-1];
      quo_r <= num_r[SUM_W-1] ? unsigned'(-num_r) : unsigned'(num_r);
      rem_r <= '0;
      bit_r <= '0;
    end
    if (state_r == B_DIV) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      bit_r <= bit_r + BCNT_W'(1);
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_range_r  <= (status_r == ST_OK) ? range_r : '0;
      out_mean_r   <= (status_r == ST_OK) ? DATA_W'(mean_full) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_range  = out_range_r;
  assign out_mean   = out_mean_r;
  assign out_status = out_status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_range_r == '0 && out_mean_r == '0))
    else $error("error status result carries nonzero figures");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (bit_r <= BCNT_W'(SUM_W - 1)))
    else $error("divide step count ran past the dividend width");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("pending result dropped before it was taken");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == B_PREP))
    else $error("queue popped without starting a result");

endmodule

FILE: design/trimmed_range_mean_stats.sv
// Trimmed range and mean over one subsample of Q16.16 samples.
//
// Input words arrive on the in_ stream channel: tdata holds the sample,
// tuser flags a missing sample (skipped) and tlast marks the final word of
// the subsample. Each non-missing word updates a count, a running sum and
// the two smallest and two largest values; the front end takes one word per
// cycle while the queue is not full. The word carrying tlast hands those
// totals to a two-entry queue and clears the accumulator for the next
// subsample. The back end pops one entry, works out the status, the range
// and the numerator of the mean, then runs a restoring divide that resolves
// one quotient bit per cycle; a result with ok status then goes to the
// out_ channel. An error status skips the divide. Short subsamples are
// absorbed by the queue; when it is full, in_tready drops. A result waits
// in the output register while out_tready is low, and the back end starts
// on the next queued entry meanwhile. cfg_we writes the trim mode bit,
// which is sampled with each tlast word. rst_n clears the accumulator, the
// queue, the back end and the trim mode; no result is pending after reset.
module trimmed_range_mean_stats #(
  parameter int MAX_SAMPLES = trmstat_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = trmstat_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,     // trim_mode
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,     // sample
  input  logic                                  in_tuser,      // is_missing
  input  logic                                  in_tlast,      // is_last
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [2 * trmstat_pkg::DATA_W-1:0]    out_tdata,     // range_out, mean_out
  output logic [trmstat_pkg::STAT_W-1:0]        out_tuser      // status
);

  import trmstat_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int REC_W = 1 + CNT_W + SUM_W + 4 * SAMPLE_BITS;

  logic              trim_mode_r;
  logic              q_push, q_pop, q_full, q_empty;
  logic [REC_W-1:0]  q_wdata, q_rdata;
  logic [DATA_W-1:0] res_range, res_mean;

  // The user must write the trim mode register only between subsamples; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_mode_r <= 1'b0;
    end else if (cfg_we) begin
      trim_mode_r <= cfg_wdata;
    end
  end

  trmstat_front #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .REC_W       (REC_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .trim_mode  (trim_mode_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_sample  (in_tdata[SAMPLE_BITS-1:0]),
    .in_missing (in_tuser),
    .in_last    (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  trmstat_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  trmstat_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .REC_W       (REC_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_range  (res_range),
    .out_mean   (res_mean),
    .out_status (out_tuser)
  );

  // Range in the low half, mean in the high half.
  assign out_tdata = {res_mean, res_range};

endmodule
